// ----- hdl/cpcr_pkg.sv -----
// Package for the circle pair collision resolver.
// Fixed-point widths, pipeline depths and the stage sideband type.
// No dependencies.
`default_nettype none
package cpcr_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int NSHIFT      = 28;
  localparam int GAIN_W      = 16;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd52429;
  localparam int RAD_W       = 16;
  localparam int RAD_SHIFT   = FRAC_BITS - 8;
  localparam int RSUM_W      = RAD_W + 1 + RAD_SHIFT;
  localparam int DIFF_W      = 33;
  localparam int SQ_W        = 2 * DIFF_W;
  localparam int ROOT_W      = DIFF_W;
  localparam int SQRT_STAGES = ROOT_W;
  localparam int REM_W       = ROOT_W + 4;
  localparam int Q_W         = NSHIFT + 1;
  localparam int DIV_STAGES  = Q_W;
  localparam int P_W         = DIFF_W + Q_W;
  localparam int S_W         = P_W + 2;
  localparam int CL_W        = S_W - NSHIFT;
  localparam int SUM_W       = CL_W + 2;
  localparam int LAT         = 3 + SQRT_STAGES + 1 + DIV_STAGES + 6;

  localparam logic [ROOT_W-1:0] ZERO_DIST = ROOT_W'((64'd1 << FRAC_BITS) / 100);
  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [31:0]        ax;
    logic [31:0]        ay;
    logic [31:0]        avx;
    logic [31:0]        avy;
    logic [31:0]        bx;
    logic [31:0]        by;
    logic [31:0]        bvx;
    logic [31:0]        bvy;
    logic [RSUM_W-1:0]  rsum;
    logic [31:0]        aim;
    logic [31:0]        bim;
    logic [DIFF_W-1:0]  imsum;
    logic [DIFF_W-1:0]  mx;
    logic [DIFF_W-1:0]  my;
    logic               nx;
    logic               ny;
    logic [DIFF_W-1:0]  dvmx;
    logic [DIFF_W-1:0]  dvmy;
    logic               dvnx;
    logic               dvny;
    logic               zero;
    logic               contact;
    logic               active;
    logic [RSUM_W-1:0]  pen;
  } sb_t;

endpackage
`default_nettype wire

// ----- hdl/circle_pair_collision_resolve_core.sv -----
// Circle pair collision resolver, top level. Uses cpcr_pkg, cpcr_sqrt, cpcr_div.
// Pipeline from accepted word to result word: 3 front stages, 33 square root
// stages, 1 contact stage, 29 divider stages, 6 multiply stages.
// Throughput: one word per cycle; the whole pipeline holds when the output
// register is full and not taken.
// Reset (rst, synchronous): clears all valid bits, gain returns to 52429.
`default_nettype none
module circle_pair_collision_resolve_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] a_pos_x,
  input  wire logic signed [31:0] a_pos_y,
  input  wire logic signed [31:0] a_vel_x,
  input  wire logic signed [31:0] a_vel_y,
  input  wire logic [15:0]        a_radius,
  input  wire logic [31:0]        a_inv_mass,
  input  wire logic signed [31:0] b_pos_x,
  input  wire logic signed [31:0] b_pos_y,
  input  wire logic signed [31:0] b_vel_x,
  input  wire logic signed [31:0] b_vel_y,
  input  wire logic [15:0]        b_radius,
  input  wire logic [31:0]        b_inv_mass,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      a_new_x,
  output logic signed [31:0]      a_new_y,
  output logic signed [31:0]      a_new_vx,
  output logic signed [31:0]      a_new_vy,
  output logic signed [31:0]      b_new_x,
  output logic signed [31:0]      b_new_y,
  output logic signed [31:0]      b_new_vx,
  output logic signed [31:0]      b_new_vy,
  output logic                    contact
);

  localparam int RW = cpcr_pkg::RSUM_W;
  localparam int QW = cpcr_pkg::Q_W;
  localparam int DW = cpcr_pkg::DIFF_W;
  localparam int CW = cpcr_pkg::CL_W;
  localparam int SW = cpcr_pkg::S_W;
  localparam int NS = cpcr_pkg::NSHIFT;

  function automatic logic [31:0] adj(input logic [31:0] base, input logic [CW-1:0] amt,
                                      input logic sub);
    logic [cpcr_pkg::SUM_W-1:0] b;
    logic [cpcr_pkg::SUM_W-1:0] a;
    logic [cpcr_pkg::SUM_W-1:0] r;
    b = {{(cpcr_pkg::SUM_W-32){base[31]}}, base};
    a = cpcr_pkg::SUM_W'(amt);
    r = sub ? b - a : b + a;
    if (!r[cpcr_pkg::SUM_W-1] && (|r[cpcr_pkg::SUM_W-2:31])) return cpcr_pkg::SAT_MAX;
    if (r[cpcr_pkg::SUM_W-1] && !(&r[cpcr_pkg::SUM_W-2:31])) return cpcr_pkg::SAT_MIN;
    return r[31:0];
  endfunction

  logic                        en;
  logic [cpcr_pkg::LAT-1:0]    vld;
  logic [cpcr_pkg::GAIN_W-1:0] gain;

  assign en        = !vld[cpcr_pkg::LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[cpcr_pkg::LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      gain <= cpcr_pkg::GAIN_RESET;
    end else begin
      if (en) vld <= {vld[cpcr_pkg::LAT-2:0], in_valid};
      if (cfg_we) gain <= cfg_wdata;
    end
  end

  // front: offsets, magnitudes, squares
  cpcr_pkg::sb_t sb_in, sb1, sb2, sb3;
  logic [DW-1:0] dx, dy, dvx, dvy;
  logic [cpcr_pkg::SQ_W-1:0] sqx, sqy, rad;

  always_comb begin
    dx  = {b_pos_x[31], b_pos_x} - {a_pos_x[31], a_pos_x};
    dy  = {b_pos_y[31], b_pos_y} - {a_pos_y[31], a_pos_y};
    dvx = {b_vel_x[31], b_vel_x} - {a_vel_x[31], a_vel_x};
    dvy = {b_vel_y[31], b_vel_y} - {a_vel_y[31], a_vel_y};
    sb_in.ax      = a_pos_x;
    sb_in.ay      = a_pos_y;
    sb_in.avx     = a_vel_x;
    sb_in.avy     = a_vel_y;
    sb_in.bx      = b_pos_x;
    sb_in.by      = b_pos_y;
    sb_in.bvx     = b_vel_x;
    sb_in.bvy     = b_vel_y;
    sb_in.rsum    = RW'({1'b0, a_radius} + {1'b0, b_radius}) << cpcr_pkg::RAD_SHIFT;
    sb_in.aim     = a_inv_mass;
    sb_in.bim     = b_inv_mass;
    sb_in.imsum   = {1'b0, a_inv_mass} + {1'b0, b_inv_mass};
    sb_in.mx      = dx[DW-1] ? DW'(-dx) : dx;
    sb_in.my      = dy[DW-1] ? DW'(-dy) : dy;
    sb_in.nx      = dx[DW-1];
    sb_in.ny      = dy[DW-1];
    sb_in.dvmx    = dvx[DW-1] ? DW'(-dvx) : dvx;
    sb_in.dvmy    = dvy[DW-1] ? DW'(-dvy) : dvy;
    sb_in.dvnx    = dvx[DW-1];
    sb_in.dvny    = dvy[DW-1];
    sb_in.zero    = (dx == '0) && (dy == '0);
    sb_in.contact = 1'b0;
    sb_in.active  = 1'b0;
    sb_in.pen     = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb1 <= sb_in;
      sqx <= sb1.mx * sb1.mx;
      sqy <= sb1.my * sb1.my;
      sb2 <= sb1;
      rad <= sqx + sqy;
      sb3 <= sb2;
    end
  end

  // square root window
  logic [cpcr_pkg::ROOT_W-1:0] root;
  cpcr_pkg::sb_t sbq [cpcr_pkg::SQRT_STAGES];

  cpcr_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (rad),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sbq[0] <= sb3;
      for (int k = 1; k < cpcr_pkg::SQRT_STAGES; k++) sbq[k] <= sbq[k-1];
    end
  end

  // contact test
  cpcr_pkg::sb_t sbq_o, sbd_in, sbd;
  logic [cpcr_pkg::ROOT_W-1:0] sep, sep_d;

  always_comb begin
    sbq_o  = sbq[cpcr_pkg::SQRT_STAGES-1];
    sep    = sbq_o.zero ? cpcr_pkg::ZERO_DIST : root;
    sbd_in = sbq_o;
    sbd_in.contact = cpcr_pkg::ROOT_W'(sbq_o.rsum) > sep;
    sbd_in.active  = sbd_in.contact && (sbq_o.imsum != '0) && !sbq_o.zero;
    sbd_in.pen     = sbq_o.rsum - RW'(sep);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sbd   <= sbd_in;
      sep_d <= sep;
    end
  end

  // normal and mass weights
  logic [QW-1:0] nmx_q, nmy_q, wa_q, wb_q;
  cpcr_pkg::sb_t sbv [cpcr_pkg::DIV_STAGES];

  cpcr_div u_div_nx (.clk(clk), .en(en), .num(sbd.mx), .den(sep_d), .quo(nmx_q));
  cpcr_div u_div_ny (.clk(clk), .en(en), .num(sbd.my), .den(sep_d), .quo(nmy_q));
  cpcr_div u_div_wa (.clk(clk), .en(en), .num({1'b0, sbd.aim}), .den(sbd.imsum),
                     .quo(wa_q));
  cpcr_div u_div_wb (.clk(clk), .en(en), .num({1'b0, sbd.bim}), .den(sbd.imsum),
                     .quo(wb_q));

  always_ff @(posedge clk) begin
    if (en) begin
      sbv[0] <= sbd;
      for (int k = 1; k < cpcr_pkg::DIV_STAGES; k++) sbv[k] <= sbv[k-1];
    end
  end

  // multiply stages
  cpcr_pkg::sb_t sbm0, sbm1, sbm2, sbm3, sbm4, sbm5, sbm3_in, sbm5_in;
  logic [RW+cpcr_pkg::GAIN_W-1:0] cprod;
  logic [RW-1:0]   c0, ma1, mb1, pax2, pay2, pbx2, pby2;
  logic [cpcr_pkg::P_W-1:0] p1_0, p2_0;
  logic [QW-1:0]   nmx0, nmy0, wa0, wb0, nmx1, nmy1, wa1, wb1;
  logic [QW-1:0]   nmx2, nmy2, wa2, wb2, nmx3, nmy3;
  logic [RW+QW-1:0] ma_full, mb_full, pax_f, pay_f, pbx_f, pby_f;
  logic [SW-1:0]   e1, e2, sp1, sp2, s1, smag;
  logic [CW-1:0]   closing2, ja3, jb3, vax4, vay4, vbx4, vby4;
  logic [CW+QW-1:0] ja_full, jb_full, vax_f, vay_f, vbx_f, vby_f;
  logic            sneg2, sneg3, sneg4;

  always_comb begin
    cprod   = sbv[cpcr_pkg::DIV_STAGES-1].pen * gain;
    ma_full = c0 * wa0;
    mb_full = c0 * wb0;
    e1      = SW'(p1_0);
    e2      = SW'(p2_0);
    sp1     = (sbm0.dvnx != sbm0.nx) ? SW'(-e1) : e1;
    sp2     = (sbm0.dvny != sbm0.ny) ? SW'(-e2) : e2;
    pax_f   = ma1 * nmx1;
    pay_f   = ma1 * nmy1;
    pbx_f   = mb1 * nmx1;
    pby_f   = mb1 * nmy1;
    smag    = SW'(-s1);
    ja_full = closing2 * wa2;
    jb_full = closing2 * wb2;
    vax_f   = ja3 * nmx3;
    vay_f   = ja3 * nmy3;
    vbx_f   = jb3 * nmx3;
    vby_f   = jb3 * nmy3;

    sbm3_in = sbm2;
    if (sbm2.active) begin
      sbm3_in.ax = adj(sbm2.ax, CW'(pax2), !sbm2.nx);
      sbm3_in.ay = adj(sbm2.ay, CW'(pay2), !sbm2.ny);
      sbm3_in.bx = adj(sbm2.bx, CW'(pbx2), sbm2.nx);
      sbm3_in.by = adj(sbm2.by, CW'(pby2), sbm2.ny);
    end

    sbm5_in = sbm4;
    if (sbm4.active && sneg4) begin
      sbm5_in.avx = adj(sbm4.avx, vax4, !sbm4.nx);
      sbm5_in.avy = adj(sbm4.avy, vay4, !sbm4.ny);
      sbm5_in.bvx = adj(sbm4.bvx, vbx4, sbm4.nx);
      sbm5_in.bvy = adj(sbm4.bvy, vby4, sbm4.ny);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sbm0 <= sbv[cpcr_pkg::DIV_STAGES-1];
      c0   <= cprod[cpcr_pkg::GAIN_W +: RW];
      p1_0 <= sbv[cpcr_pkg::DIV_STAGES-1].dvmx * nmx_q;
      p2_0 <= sbv[cpcr_pkg::DIV_STAGES-1].dvmy * nmy_q;
      nmx0 <= nmx_q;
      nmy0 <= nmy_q;
      wa0  <= wa_q;
      wb0  <= wb_q;

      sbm1 <= sbm0;
      ma1  <= ma_full[NS +: RW];
      mb1  <= mb_full[NS +: RW];
      s1   <= sp1 + sp2;
      nmx1 <= nmx0;
      nmy1 <= nmy0;
      wa1  <= wa0;
      wb1  <= wb0;

      sbm2     <= sbm1;
      pax2     <= pax_f[NS +: RW];
      pay2     <= pay_f[NS +: RW];
      pbx2     <= pbx_f[NS +: RW];
      pby2     <= pby_f[NS +: RW];
      closing2 <= s1[SW-1] ? smag[NS +: CW] : '0;
      sneg2    <= s1[SW-1];
      nmx2     <= nmx1;
      nmy2     <= nmy1;
      wa2      <= wa1;
      wb2      <= wb1;

      sbm3  <= sbm3_in;
      ja3   <= ja_full[NS +: CW];
      jb3   <= jb_full[NS +: CW];
      sneg3 <= sneg2;
      nmx3  <= nmx2;
      nmy3  <= nmy2;

      sbm4  <= sbm3;
      vax4  <= vax_f[NS +: CW];
      vay4  <= vay_f[NS +: CW];
      vbx4  <= vbx_f[NS +: CW];
      vby4  <= vby_f[NS +: CW];
      sneg4 <= sneg3;

      sbm5 <= sbm5_in;
    end
  end

  assign a_new_x  = sbm5.ax;
  assign a_new_y  = sbm5.ay;
  assign a_new_vx = sbm5.avx;
  assign a_new_vy = sbm5.avy;
  assign b_new_x  = sbm5.bx;
  assign b_new_y  = sbm5.by;
  assign b_new_vx = sbm5.bvx;
  assign b_new_vy = sbm5.bvy;
  assign contact  = sbm5.contact;

endmodule
`default_nettype wire

// ----- hdl/cpcr_sqrt.sv -----
// Pipelined floor square root, one result bit per stage.
// Depends on cpcr_pkg.
`default_nettype none
module cpcr_sqrt (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [cpcr_pkg::SQ_W-1:0]     radicand,
  output logic      [cpcr_pkg::ROOT_W-1:0]   root
);

  logic [cpcr_pkg::SQ_W-1:0]   val_q  [cpcr_pkg::SQRT_STAGES];
  logic [cpcr_pkg::REM_W-1:0]  rem_q  [cpcr_pkg::SQRT_STAGES];
  logic [cpcr_pkg::ROOT_W-1:0] root_q [cpcr_pkg::SQRT_STAGES];

  for (genvar k = 0; k < cpcr_pkg::SQRT_STAGES; k++) begin : g_stage
    logic [cpcr_pkg::SQ_W-1:0]   val_in;
    logic [cpcr_pkg::REM_W-1:0]  rem_in;
    logic [cpcr_pkg::ROOT_W-1:0] root_in;
    logic [cpcr_pkg::REM_W-1:0]  rem_sh;
    logic [cpcr_pkg::REM_W-1:0]  trial;
    logic                        ge;

    if (k == 0) begin : g_first
      assign val_in  = radicand;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign val_in  = val_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign rem_sh = {rem_in[cpcr_pkg::REM_W-3:0], val_in[cpcr_pkg::SQ_W-1 -: 2]};
    assign trial  = cpcr_pkg::REM_W'({root_in, 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        val_q[k]  <= val_in << 2;
        rem_q[k]  <= ge ? rem_sh - trial : rem_sh;
        root_q[k] <= {root_in[cpcr_pkg::ROOT_W-2:0], ge};
      end
    end
  end

  assign root = root_q[cpcr_pkg::SQRT_STAGES-1];

endmodule
`default_nettype wire

// ----- hdl/cpcr_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Quotient of (num << NSHIFT) / den for num <= den. Depends on cpcr_pkg.
`default_nettype none
module cpcr_div (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [cpcr_pkg::DIFF_W-1:0]   num,
  input  wire logic [cpcr_pkg::DIFF_W-1:0]   den,
  output logic      [cpcr_pkg::Q_W-1:0]      quo
);

  logic [cpcr_pkg::DIFF_W-1:0] r_q [cpcr_pkg::DIV_STAGES];
  logic [cpcr_pkg::DIFF_W-1:0] d_q [cpcr_pkg::DIV_STAGES];
  logic [cpcr_pkg::Q_W-1:0]    q_q [cpcr_pkg::DIV_STAGES];

  for (genvar k = 0; k < cpcr_pkg::DIV_STAGES; k++) begin : g_stage
    logic [cpcr_pkg::DIFF_W:0]   t;
    logic [cpcr_pkg::DIFF_W:0]   diff;
    logic [cpcr_pkg::DIFF_W-1:0] d_in;
    logic [cpcr_pkg::Q_W-1:0]    q_in;
    logic                        ge;

    if (k == 0) begin : g_first
      assign t    = {1'b0, num};
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_next
      assign t    = {r_q[k-1], 1'b0};
      assign d_in = d_q[k-1];
      assign q_in = q_q[k-1];
    end

    assign diff = t - {1'b0, d_in};
    assign ge   = t >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        r_q[k] <= ge ? diff[cpcr_pkg::DIFF_W-1:0] : t[cpcr_pkg::DIFF_W-1:0];
        d_q[k] <= d_in;
        q_q[k] <= {q_in[cpcr_pkg::Q_W-2:0], ge};
      end
    end
  end

  assign quo = q_q[cpcr_pkg::DIV_STAGES-1];

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Testbench for circle_pair_collision_resolve_core: directed and random circle pairs,
// an independent fixed-point predictor and an in-order scoreboard.
// Depends on cpcr_pkg and the core RTL.
module testbench;

  typedef struct {
    logic signed [31:0] ax, ay, avx, avy;
    logic [15:0] ar;
    logic [31:0] aim;
    logic signed [31:0] bx, by, bvx, bvy;
    logic [15:0] br;
    logic [31:0] bim;
  } pair_t;

  typedef struct {
    logic signed [31:0] ax, ay, avx, avy, bx, by, bvx, bvy;
    logic contact;
  } resolved_t;

  class resolve_board;
    resolved_t pending[$];
    logic [15:0] gain;
    int errors;

    function new();
      gain = cpcr_pkg::GAIN_RESET;
      errors = 0;
    endfunction

    function automatic logic [63:0] root66(logic [65:0] v);
      logic [67:0] rem;
      logic [67:0] trial;
      logic [63:0] r;
      rem = 0;
      r = 0;
      for (int i = 32; i >= 0; i--) begin
        rem = (rem << 2) | ((v >> (2 * i)) & 66'd3);
        r = r << 1;
        trial = {r, 1'b1};
        if (rem >= trial) begin
          rem = rem - trial;
          r = r | 64'd1;
        end
      end
      return r;
    endfunction

    function automatic logic signed [31:0] clamp(logic signed [127:0] v);
      if (v > 128'sh7FFFFFFF) return cpcr_pkg::SAT_MAX;
      if (v < -128'sh80000000) return cpcr_pkg::SAT_MIN;
      return v[31:0];
    endfunction

    function automatic logic signed [127:0] shove(int sg, logic [127:0] m, logic [127:0] nm);
      logic signed [127:0] p;
      p = (m * nm) >> cpcr_pkg::NSHIFT;
      return sg < 0 ? -p : (sg > 0 ? p : 0);
    endfunction

    function void note(pair_t p);
      resolved_t r;
      logic signed [127:0] dx, dy, dvx, dvy, s, p1, p2;
      logic [127:0] mx, my, sep, rsum, imsum, nmx, nmy, wa, wb, c, ma, mb, cl, ja, jb;
      logic zero;
      int sgx, sgy;
      r = '{p.ax, p.ay, p.avx, p.avy, p.bx, p.by, p.bvx, p.bvy, 1'b0};
      dx = 128'(p.bx) - 128'(p.ax);
      dy = 128'(p.by) - 128'(p.ay);
      mx = dx < 0 ? -dx : dx;
      my = dy < 0 ? -dy : dy;
      zero = (mx == 0 && my == 0);
      sep = zero ? 128'(cpcr_pkg::ZERO_DIST) : 128'(root66(66'(mx * mx + my * my)));
      rsum = (128'(p.ar) + 128'(p.br)) << (cpcr_pkg::FRAC_BITS - 8);
      if (rsum > sep) begin
        r.contact = 1'b1;
        imsum = 128'(p.aim) + 128'(p.bim);
        if (imsum != 0 && !zero) begin
          nmx = (mx << cpcr_pkg::NSHIFT) / sep;
          nmy = (my << cpcr_pkg::NSHIFT) / sep;
          sgx = dx < 0 ? -1 : (dx > 0 ? 1 : 0);
          sgy = dy < 0 ? -1 : (dy > 0 ? 1 : 0);
          wa = (128'(p.aim) << cpcr_pkg::NSHIFT) / imsum;
          wb = (128'(p.bim) << cpcr_pkg::NSHIFT) / imsum;
          c = ((rsum - sep) * gain) >> 16;
          ma = (c * wa) >> cpcr_pkg::NSHIFT;
          mb = (c * wb) >> cpcr_pkg::NSHIFT;
          dvx = 128'(p.bvx) - 128'(p.avx);
          dvy = 128'(p.bvy) - 128'(p.avy);
          p1 = (dvx < 0 ? -dvx : dvx) * nmx;
          p2 = (dvy < 0 ? -dvy : dvy) * nmy;
          if ((dvx < 0) != (sgx < 0)) p1 = -p1;
          if ((dvy < 0) != (sgy < 0)) p2 = -p2;
          s = p1 + p2;
          r.ax = clamp(128'(p.ax) - shove(sgx, ma, nmx));
          r.ay = clamp(128'(p.ay) - shove(sgy, ma, nmy));
          r.bx = clamp(128'(p.bx) + shove(sgx, mb, nmx));
          r.by = clamp(128'(p.by) + shove(sgy, mb, nmy));
          if (s < 0) begin
            cl = (-s) >> cpcr_pkg::NSHIFT;
            ja = (cl * wa) >> cpcr_pkg::NSHIFT;
            jb = (cl * wb) >> cpcr_pkg::NSHIFT;
            r.avx = clamp(128'(p.avx) - shove(sgx, ja, nmx));
            r.avy = clamp(128'(p.avy) - shove(sgy, ja, nmy));
            r.bvx = clamp(128'(p.bvx) + shove(sgx, jb, nmx));
            r.bvy = clamp(128'(p.bvy) + shove(sgy, jb, nmy));
          end
        end
      end
      pending.push_back(r);
    endfunction

    function void cmp(string nm, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $error("%s expected %0d got %0d", nm, $signed(e), $signed(a));
        errors++;
      end
    endfunction

    function void check(resolved_t a);
      resolved_t e;
      if (pending.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("a_new_x", e.ax, a.ax);
      cmp("a_new_y", e.ay, a.ay);
      cmp("a_new_vx", e.avx, a.avx);
      cmp("a_new_vy", e.avy, a.avy);
      cmp("b_new_x", e.bx, a.bx);
      cmp("b_new_y", e.by, a.by);
      cmp("b_new_vx", e.bvx, a.bvx);
      cmp("b_new_vy", e.bvy, a.bvy);
      cmp("contact", 32'(e.contact), 32'(a.contact));
    endfunction
  endclass

  logic clk, rst, cfg_we, in_valid, in_ready, out_valid, out_ready;
  logic [15:0] cfg_wdata;
  pair_t drv;
  resolved_t got;
  resolve_board board;
  int cycles;
  int idle_pct;
  bit hold_rx;

  circle_pair_collision_resolve_core DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .a_pos_x(drv.ax), .a_pos_y(drv.ay), .a_vel_x(drv.avx), .a_vel_y(drv.avy),
    .a_radius(drv.ar), .a_inv_mass(drv.aim),
    .b_pos_x(drv.bx), .b_pos_y(drv.by), .b_vel_x(drv.bvx), .b_vel_y(drv.bvy),
    .b_radius(drv.br), .b_inv_mass(drv.bim),
    .out_valid(out_valid), .out_ready(out_ready),
    .a_new_x(got.ax), .a_new_y(got.ay), .a_new_vx(got.avx), .a_new_vy(got.avy),
    .b_new_x(got.bx), .b_new_y(got.by), .b_new_vx(got.bvx), .b_new_vy(got.bvy),
    .contact(got.contact)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("testbench: FAIL");
      $finish;
    end
    if (!rst && out_valid && out_ready) board.check(got);
    if (!rst && in_valid && in_ready) board.note(drv);
  end

  // receiver
  initial begin
    out_ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_rx) out_ready <= 1'b0;
      else out_ready <= ($urandom_range(99) >= idle_pct);
      @(negedge clk);
    end
  end

  function automatic logic signed [31:0] near(logic signed [31:0] base, int span);
    return base + $signed(32'($urandom_range(2 * span))) - span;
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int k;
    k = $urandom_range(9);
    p.ax = $urandom; p.ay = $urandom; p.avx = $urandom; p.avy = $urandom;
    p.bvx = $urandom; p.bvy = $urandom;
    p.ar = 16'($urandom); p.br = 16'($urandom); p.aim = $urandom; p.bim = $urandom;
    if (k < 7) begin
      p.bx = near(p.ax, 1 << ($urandom_range(8, 25)));
      p.by = near(p.ay, 1 << ($urandom_range(8, 25)));
      if (k == 0) begin
        p.avx = $signed(32'($urandom_range(1 << 20))) - (1 << 19);
        p.avy = $signed(32'($urandom_range(1 << 20))) - (1 << 19);
      end
      if (k == 1) p.ar = 16'($urandom_range(255));
    end else if (k == 7) begin
      p.bx = p.ax; p.by = p.ay;
    end else begin
      p.bx = $urandom; p.by = $urandom;
    end
    if ($urandom_range(15) == 0) p.aim = 0;
    if ($urandom_range(15) == 0) p.bim = 0;
    return p;
  endfunction

  // valid stays up after acceptance until the next word or an idle cycle replaces it
  task automatic send(pair_t p);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    drv <= p;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_gain(logic [15:0] g);
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (cpcr_pkg::LAT + 5) @(negedge clk);
    cfg_wdata <= g;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.gain = g;
  endtask

  task automatic directed();
    pair_t p;
    p = '{32'sd0, 32'sd0, 32'sd65536, 32'sd0, 16'd256, 32'h8000_0000,
          32'sd65536, 32'sd0, -32'sd65536, 32'sd0, 16'd256, 32'h8000_0000};
    send(p);
    p.bx = 0; send(p);
    p.bx = 32'sh7FFF_FFFF; p.ax = 32'sh8000_0000; p.ar = 16'hFFFF; p.br = 16'hFFFF;
    send(p);
    p = '{32'sh7FFF_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF,
          32'hFFFF_FFFF, 32'sh7FFF_8000, 32'sh8000_8000, 32'sh8000_0000, 32'sh7FFF_FFFF,
          16'hFFFF, 32'hFFFF_FFFF};
    send(p);
    p.aim = 0; p.bim = 0; send(p);
    p.aim = 0; p.bim = 32'hFFFF_FFFF; send(p);
    p.ar = 16'd0; p.br = 16'd0; send(p);
    p.bx = p.ax; p.by = p.ay; p.ar = 16'd1; p.br = 16'd1; send(p);
    p.ar = 16'd0; p.br = 16'd0; send(p);
    p = '{32'sd100, -32'sd50, 32'sd0, 32'sd0, 16'd10, 32'd1,
          32'sd100, 32'sd400, 32'sd0, 32'sd0, 16'd10, 32'd3};
    send(p);
    p.avy = 32'sd1000; send(p);
    p.avy = -32'sd1000; send(p);
    p.by = -32'sd600; send(p);
  endtask

  initial begin
    logic [15:0] gains [5];
    board = new();
    cycles = 0;
    rst = 1; cfg_we = 0; cfg_wdata = 0; in_valid = 0; hold_rx = 0; idle_pct = 32;
    drv = '{default: '0};
    repeat (4) @(negedge clk);
    rst = 0;
    directed();
    gains = '{16'd0, 16'hFFFF, 16'd1, 16'h8000, 16'd52429};
    for (int g = 0; g < 5; g++) begin
      set_gain(gains[g] == 16'd0 && g == 0 ? 16'd0 : gains[g]);
      if (g == 1) begin
        idle_pct = 0;
        fork
          begin
            hold_rx = 1;
            repeat (300) @(negedge clk);
            hold_rx = 0;
          end
        join_none
      end
      for (int i = 0; i < 340; i++) send(rand_pair());
      idle_pct = 32;
    end
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (cpcr_pkg::LAT + 10) @(negedge clk);
    if (board.errors == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end
endmodule

// ----- circle_pair_collision_resolve_core.f -----
hdl/cpcr_pkg.sv
hdl/cpcr_sqrt.sv
hdl/cpcr_div.sv
hdl/circle_pair_collision_resolve_core.sv
tb/sv/testbench.sv
